// File: rtl/rgbhsv_pkg.sv
// Shared constants, flag struct and width helpers for the RGB to HSV converter.
// No dependencies; every other file that holds code uses this package.
package rgbhsv_pkg;

  localparam int CHANNEL_BITS_DEF = 8;
  localparam int HUE_W            = 9;
  localparam int HUE_WRAP         = 360;
  localparam int HUE_STEP         = 60;

  typedef struct packed {
    logic hue_zero;
    logic sat_zero;
  } rgbhsv_flags_t;

  // quotient bits: hue needs 9, saturation needs the channel width
  function automatic int quot_bits(input int cb);
    return (cb > HUE_W) ? cb : HUE_W;
  endfunction

  // remainder/dividend bits, covers 721*CMAX, CMAX*CMAX and the shifted divisors
  function automatic int rem_bits(input int cb);
    return 2 * cb + 10;
  endfunction

endpackage

// File: rtl/rgbhsv_ifs.sv
// Valid/ready channel interfaces for pixel words in and HSV words out.
// Depends on rgbhsv_pkg.
interface rgbhsv_pix_if #(parameter int CB = rgbhsv_pkg::CHANNEL_BITS_DEF);
  logic          valid;
  logic          ready;
  logic [CB-1:0] red;
  logic [CB-1:0] green;
  logic [CB-1:0] blue;
  modport source (output valid, red, green, blue, input ready);
  modport sink   (input valid, red, green, blue, output ready);
endinterface

interface rgbhsv_hsv_if #(parameter int CB = rgbhsv_pkg::CHANNEL_BITS_DEF);
  logic                           valid;
  logic                           ready;
  logic [rgbhsv_pkg::HUE_W-1:0]   hue;
  logic [CB-1:0]                  saturation;
  logic [CB-1:0]                  brightness;
  modport source (output valid, hue, saturation, brightness, input ready);
  modport sink   (input valid, hue, saturation, brightness, output ready);
endinterface

// File: rtl/rgbhsv_front.sv
// Front stage: max, min, delta, sector numerator and both divider operands.
// Depends on rgbhsv_pkg and rgbhsv_ifs.
module rgbhsv_front #(
  parameter int CB = rgbhsv_pkg::CHANNEL_BITS_DEF
) (
  input  logic                                  clk,
  input  logic                                  rst_n,
  rgbhsv_pix_if.sink                            pix,
  output logic                                  dn_valid,
  input  logic                                  dn_ready,
  output logic [rgbhsv_pkg::rem_bits(CB)-1:0]   dn_rem_h,
  output logic [CB:0]                           dn_div_h,
  output logic [rgbhsv_pkg::rem_bits(CB)-1:0]   dn_rem_s,
  output logic [CB-1:0]                         dn_div_s,
  output logic [CB-1:0]                         dn_bright,
  output rgbhsv_pkg::rgbhsv_flags_t             dn_flags
);
  import rgbhsv_pkg::*;

  localparam int RW = rem_bits(CB);
  localparam int SW = CB + 4;

  logic [CB-1:0]        mx, mn, dl;
  logic signed [SW-1:0] rs, gs, bs, ds, diff, wrapd;
  logic [RW-1:0]        hue_num, sat_num;
  logic                 valid_r, load;
  logic [RW-1:0]        rem_h_r, rem_s_r;
  logic [CB:0]          div_h_r;
  logic [CB-1:0]        div_s_r, bright_r;
  rgbhsv_flags_t        flags_r;

  always_comb begin
    mx = pix.red;
    if (pix.green > mx) mx = pix.green;
    if (pix.blue > mx) mx = pix.blue;
    mn = pix.red;
    if (pix.green < mn) mn = pix.green;
    if (pix.blue < mn) mn = pix.blue;
    dl = mx - mn;
    rs = $signed(SW'(pix.red));
    gs = $signed(SW'(pix.green));
    bs = $signed(SW'(pix.blue));
    ds = $signed(SW'(dl));
    if (pix.red == mx) begin
      diff = gs - bs;
    end else if (pix.green == mx) begin
      diff = (ds <<< 1) + bs - rs;
    end else begin
      diff = (ds <<< 2) + rs - gs;
    end
    // wrap negative hue by 6 sectors
    wrapd   = (diff < 0) ? (diff + (ds <<< 2) + (ds <<< 1)) : diff;
    hue_num = RW'($unsigned(wrapd)) * RW'(2 * HUE_STEP) + RW'(dl);
    sat_num = (RW'(dl) << CB) - RW'(dl);
  end

  assign pix.ready = !valid_r || dn_ready;
  assign load      = pix.valid && pix.ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (pix.ready) begin
      valid_r <= pix.valid;
    end
    if (load) begin
      rem_h_r          <= hue_num;
      div_h_r          <= {dl, 1'b0};
      rem_s_r          <= sat_num;
      div_s_r          <= mx;
      bright_r         <= mx;
      flags_r.hue_zero <= (dl == '0);
      flags_r.sat_zero <= (mx == '0);
    end
  end

  assign dn_valid  = valid_r;
  assign dn_rem_h  = rem_h_r;
  assign dn_div_h  = div_h_r;
  assign dn_rem_s  = rem_s_r;
  assign dn_div_s  = div_s_r;
  assign dn_bright = bright_r;
  assign dn_flags  = flags_r;

endmodule

// File: rtl/rgbhsv_cell.sv
// One restoring-division cell: resolves quotient bit STEP of both the hue and
// saturation divisions and passes the word on. Depends on rgbhsv_pkg.
module rgbhsv_cell #(
  parameter int CB   = rgbhsv_pkg::CHANNEL_BITS_DEF,
  parameter int STEP = 0
) (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  logic                                  up_valid,
  output logic                                  up_ready,
  input  logic [rgbhsv_pkg::rem_bits(CB)-1:0]   up_rem_h,
  input  logic [CB:0]                           up_div_h,
  input  logic [rgbhsv_pkg::quot_bits(CB)-1:0]  up_q_h,
  input  logic [rgbhsv_pkg::rem_bits(CB)-1:0]   up_rem_s,
  input  logic [CB-1:0]                         up_div_s,
  input  logic [rgbhsv_pkg::quot_bits(CB)-1:0]  up_q_s,
  input  logic [CB-1:0]                         up_bright,
  input  rgbhsv_pkg::rgbhsv_flags_t             up_flags,
  output logic                                  dn_valid,
  input  logic                                  dn_ready,
  output logic [rgbhsv_pkg::rem_bits(CB)-1:0]   dn_rem_h,
  output logic [CB:0]                           dn_div_h,
  output logic [rgbhsv_pkg::quot_bits(CB)-1:0]  dn_q_h,
  output logic [rgbhsv_pkg::rem_bits(CB)-1:0]   dn_rem_s,
  output logic [CB-1:0]                         dn_div_s,
  output logic [rgbhsv_pkg::quot_bits(CB)-1:0]  dn_q_s,
  output logic [CB-1:0]                         dn_bright,
  output rgbhsv_pkg::rgbhsv_flags_t             dn_flags
);
  import rgbhsv_pkg::*;

  localparam int RW = rem_bits(CB);
  localparam int QW = quot_bits(CB);

  logic [RW-1:0] sh_h, sh_s;
  logic          ge_h, ge_s;
  logic [QW-1:0] qbit;
  logic          valid_r, load;
  logic [RW-1:0] rem_h_r, rem_s_r;
  logic [CB:0]   div_h_r;
  logic [CB-1:0] div_s_r, bright_r;
  logic [QW-1:0] q_h_r, q_s_r;
  rgbhsv_flags_t flags_r;

  always_comb begin
    sh_h = RW'(up_div_h) << STEP;
    sh_s = RW'(up_div_s) << STEP;
    ge_h = (up_rem_h >= sh_h);
    ge_s = (up_rem_s >= sh_s);
    qbit = QW'(1) << STEP;
  end

  assign up_ready = !valid_r || dn_ready;
  assign load     = up_valid && up_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (up_ready) begin
      valid_r <= up_valid;
    end
    if (load) begin
      rem_h_r  <= ge_h ? (up_rem_h - sh_h) : up_rem_h;
      rem_s_r  <= ge_s ? (up_rem_s - sh_s) : up_rem_s;
      q_h_r    <= ge_h ? (up_q_h | qbit) : up_q_h;
      q_s_r    <= ge_s ? (up_q_s | qbit) : up_q_s;
      div_h_r  <= up_div_h;
      div_s_r  <= up_div_s;
      bright_r <= up_bright;
      flags_r  <= up_flags;
    end
  end

  assign dn_valid  = valid_r;
  assign dn_rem_h  = rem_h_r;
  assign dn_div_h  = div_h_r;
  assign dn_q_h    = q_h_r;
  assign dn_rem_s  = rem_s_r;
  assign dn_div_s  = div_s_r;
  assign dn_q_s    = q_s_r;
  assign dn_bright = bright_r;
  assign dn_flags  = flags_r;

endmodule

// File: rtl/rgbhsv_out_stage.sv
// Output register: final hue wrap and zero cases, holds the HSV word for the sink.
// Depends on rgbhsv_pkg and rgbhsv_ifs.
module rgbhsv_out_stage #(
  parameter int CB = rgbhsv_pkg::CHANNEL_BITS_DEF
) (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  logic                                  up_valid,
  output logic                                  up_ready,
  input  logic [rgbhsv_pkg::quot_bits(CB)-1:0]  up_q_h,
  input  logic [rgbhsv_pkg::quot_bits(CB)-1:0]  up_q_s,
  input  logic [CB-1:0]                         up_bright,
  input  rgbhsv_pkg::rgbhsv_flags_t             up_flags,
  rgbhsv_hsv_if.source                          hsv
);
  import rgbhsv_pkg::*;

  logic             valid_r, load;
  logic [HUE_W-1:0] hue_nxt, hue_r;
  logic [CB-1:0]    sat_nxt, sat_r, bright_r;

  always_comb begin
    if (up_flags.hue_zero || (up_q_h[HUE_W-1:0] == HUE_W'(HUE_WRAP))) begin
      hue_nxt = '0;
    end else begin
      hue_nxt = up_q_h[HUE_W-1:0];
    end
    sat_nxt = up_flags.sat_zero ? '0 : up_q_s[CB-1:0];
  end

  assign up_ready = !valid_r || hsv.ready;
  assign load     = up_valid && up_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (up_ready) begin
      valid_r <= up_valid;
    end
    if (load) begin
      hue_r    <= hue_nxt;
      sat_r    <= sat_nxt;
      bright_r <= up_bright;
    end
  end

  assign hsv.valid      = valid_r;
  assign hsv.hue        = hue_r;
  assign hsv.saturation = sat_r;
  assign hsv.brightness = bright_r;

  hue_range_a: assert property (@(posedge clk) disable iff (!rst_n)
    hsv.valid |-> (hsv.hue < HUE_W'(HUE_WRAP)))
    else $error("hue out of range");

  black_sat_a: assert property (@(posedge clk) disable iff (!rst_n)
    (hsv.valid && (hsv.brightness == '0)) |-> (hsv.saturation == '0))
    else $error("saturation nonzero on black");

  grey_hue_a: assert property (@(posedge clk) disable iff (!rst_n)
    (hsv.valid && (hsv.saturation == '0)) |-> (hsv.hue == '0))
    else $error("hue nonzero on grey");

endmodule

// File: rtl/rgbhsv_ifs_top_dummy_guard.sv
// Holds no design; reserved so the interface file stays standalone.
// Depends on nothing.

// File: rtl/rgb_to_hsv_converter_top.sv
// RGB to HSV converter. Takes one pixel word per clock and returns hue (0..359 degrees,
// rounded half up), saturation floor(CMAX*delta/max) and brightness (max) per pixel, in
// order. The pipeline is one front stage, one restoring-division cell per quotient bit
// and one output register. Throughput is one pixel per clock while the sink does not
// stall; every stage has its own valid/ready so bubbles collapse when the sink stalls.
// Depends on rgbhsv_pkg, rgbhsv_ifs, rgbhsv_front, rgbhsv_cell, rgbhsv_out_stage.
module rgb_to_hsv_converter_top #(
  parameter int CHANNEL_BITS = rgbhsv_pkg::CHANNEL_BITS_DEF
) (
  input  logic          clk,
  input  logic          rst_n,
  rgbhsv_pix_if.sink    in_pix,
  rgbhsv_hsv_if.source  out_hsv
);
  import rgbhsv_pkg::*;

  localparam int CB = CHANNEL_BITS;
  localparam int RW = rem_bits(CB);
  localparam int QW = quot_bits(CB);

  logic          st_valid [QW+1];
  logic          st_ready [QW+1];
  logic [RW-1:0] st_rem_h [QW+1];
  logic [CB:0]   st_div_h [QW+1];
  logic [QW-1:0] st_q_h   [QW+1];
  logic [RW-1:0] st_rem_s [QW+1];
  logic [CB-1:0] st_div_s [QW+1];
  logic [QW-1:0] st_q_s   [QW+1];
  logic [CB-1:0] st_bright[QW+1];
  rgbhsv_flags_t st_flags [QW+1];

  assign st_q_h[0] = '0;
  assign st_q_s[0] = '0;

  rgbhsv_front #(.CB(CB)) u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .pix       (in_pix),
    .dn_valid  (st_valid[0]),
    .dn_ready  (st_ready[0]),
    .dn_rem_h  (st_rem_h[0]),
    .dn_div_h  (st_div_h[0]),
    .dn_rem_s  (st_rem_s[0]),
    .dn_div_s  (st_div_s[0]),
    .dn_bright (st_bright[0]),
    .dn_flags  (st_flags[0])
  );

  for (genvar k = 0; k < QW; k++) begin : g_cell
    rgbhsv_cell #(.CB(CB), .STEP(QW - 1 - k)) u_cell (
      .clk       (clk),
      .rst_n     (rst_n),
      .up_valid  (st_valid[k]),
      .up_ready  (st_ready[k]),
      .up_rem_h  (st_rem_h[k]),
      .up_div_h  (st_div_h[k]),
      .up_q_h    (st_q_h[k]),
      .up_rem_s  (st_rem_s[k]),
      .up_div_s  (st_div_s[k]),
      .up_q_s    (st_q_s[k]),
      .up_bright (st_bright[k]),
      .up_flags  (st_flags[k]),
      .dn_valid  (st_valid[k+1]),
      .dn_ready  (st_ready[k+1]),
      .dn_rem_h  (st_rem_h[k+1]),
      .dn_div_h  (st_div_h[k+1]),
      .dn_q_h    (st_q_h[k+1]),
      .dn_rem_s  (st_rem_s[k+1]),
      .dn_div_s  (st_div_s[k+1]),
      .dn_q_s    (st_q_s[k+1]),
      .dn_bright (st_bright[k+1]),
      .dn_flags  (st_flags[k+1])
    );
  end

  rgbhsv_out_stage #(.CB(CB)) u_out (
    .clk       (clk),
    .rst_n     (rst_n),
    .up_valid  (st_valid[QW]),
    .up_ready  (st_ready[QW]),
    .up_q_h    (st_q_h[QW]),
    .up_q_s    (st_q_s[QW]),
    .up_bright (st_bright[QW]),
    .up_flags  (st_flags[QW]),
    .hsv       (out_hsv)
  );

  // final remainders must be below their divisors for a nonzero divisor
  rem_h_a: assert property (@(posedge clk) disable iff (!rst_n)
    (st_valid[QW] && !st_flags[QW].hue_zero) |-> (st_rem_h[QW] < RW'(st_div_h[QW])))
    else $error("hue remainder not reduced");

  rem_s_a: assert property (@(posedge clk) disable iff (!rst_n)
    (st_valid[QW] && !st_flags[QW].sat_zero) |-> (st_rem_s[QW] < RW'(st_div_s[QW])))
    else $error("saturation remainder not reduced");

endmodule

// File: dv/testbench.sv
// Self-checking testbench for rgb_to_hsv_converter_top: drives pixel words with random idling
// and back-pressure, predicts hue, saturation and brightness per pixel, checks every output word.
// Depends on rgbhsv_pkg, rgbhsv_ifs and the converter RTL.
module testbench;
  import rgbhsv_pkg::*;

  localparam int CB          = CHANNEL_BITS_DEF;
  localparam int CMAX        = (1 << CB) - 1;
  localparam int CYCLE_LIMIT = 200000;
  localparam int MAX_REPORTS = 10;

  typedef struct packed {
    logic [HUE_W-1:0] hue;
    logic [CB-1:0]    sat;
    logic [CB-1:0]    val;
  } hsv_word_t;

  class hsv_scoreboard;
    hsv_word_t hsv_expected[$];
    int        failures;

    function new();
      failures = 0;
    endfunction

    function hsv_word_t convert(logic [CB-1:0] r, logic [CB-1:0] g, logic [CB-1:0] b);
      int rv, gv, bv, hi, lo, delta, num, q;
      hsv_word_t w;
      rv = int'(r);
      gv = int'(g);
      bv = int'(b);
      hi = rv;
      if (gv > hi) hi = gv;
      if (bv > hi) hi = bv;
      lo = rv;
      if (gv < lo) lo = gv;
      if (bv < lo) lo = bv;
      delta = hi - lo;
      w.val = hi[CB-1:0];
      q = (hi != 0) ? (CMAX * delta) / hi : 0;
      w.sat = q[CB-1:0];
      q = 0;
      if (delta != 0) begin
        // red wins ties, then green
        if (rv == hi)
          num = HUE_STEP * (gv - bv);
        else if (gv == hi)
          num = HUE_STEP * (2 * delta + bv - rv);
        else
          num = HUE_STEP * (4 * delta + rv - gv);
        if (num < 0) num += HUE_WRAP * delta;
        q = (2 * num + delta) / (2 * delta);
        if (q >= HUE_WRAP) q = 0;
      end
      w.hue = q[HUE_W-1:0];
      return w;
    endfunction

    function void note_pixel(logic [CB-1:0] r, logic [CB-1:0] g, logic [CB-1:0] b);
      hsv_expected.push_back(convert(r, g, b));
    endfunction

    function void flag(string what, hsv_word_t want, hsv_word_t got);
      failures++;
      if (failures <= MAX_REPORTS)
        $display("%s: expected h=%0d s=%0d v=%0d, got h=%0d s=%0d v=%0d", what,
                 want.hue, want.sat, want.val, got.hue, got.sat, got.val);
    endfunction

    function void check_hsv(hsv_word_t got);
      hsv_word_t want;
      if (hsv_expected.size() == 0) begin
        flag("unexpected word", '0, got);
        return;
      end
      want = hsv_expected.pop_front();
      if (got.hue !== want.hue || got.sat !== want.sat || got.val !== want.val)
        flag("mismatch", want, got);
    endfunction

    function int pending();
      return hsv_expected.size();
    endfunction
  endclass

  logic clk;
  logic rst_n;
  bit   steady;
  int   cycles;

  hsv_scoreboard sb = new();

  rgbhsv_pix_if #(.CB(CB)) pix_bus ();
  rgbhsv_hsv_if #(.CB(CB)) hsv_bus ();

  rgb_to_hsv_converter_top #(.CHANNEL_BITS(CB)) DUT (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_pix  (pix_bus),
    .out_hsv (hsv_bus)
  );

  logic [3*CB-1:0] corner_pixels[$] = '{
    24'h000000, 24'hFFFFFF, 24'h808080, 24'h010101,
    24'hFF0000, 24'h00FF00, 24'h0000FF,
    24'hFFFF00, 24'h00FFFF, 24'hFF00FF,  // ties for max
    24'hFF0001,                          // hue rounds up to 360 and wraps
    24'h780100,                          // hue lands exactly on one half
    24'h010000, 24'h000100, 24'h000001,
    24'hFEFF00, 24'h00FEFF, 24'hFF00FE,
    24'h7F80FF, 24'hAA5501, 24'h55AAFE, 24'hFE0155
  };

  always begin
    clk = 1'b1;
    #5;
    clk = 1'b0;
    #5;
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles >= CYCLE_LIMIT) begin
      $display("Verification failed");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (rst_n) begin
      if (pix_bus.valid && pix_bus.ready)
        sb.note_pixel(pix_bus.red, pix_bus.green, pix_bus.blue);
      if (hsv_bus.valid && hsv_bus.ready)
        sb.check_hsv('{hsv_bus.hue, hsv_bus.saturation, hsv_bus.brightness});
    end
  end

  // sink side: random stall before each word
  initial begin
    int stall;
    hsv_bus.ready = 1'b0;
    @(negedge clk);
    while (!rst_n) @(negedge clk);
    forever begin
      stall = steady ? 0 : $urandom_range(0, 7);
      if (stall > 0) begin
        hsv_bus.ready <= 1'b0;
        repeat (stall) @(negedge clk);
      end
      hsv_bus.ready <= 1'b1;
      do @(posedge clk); while (!hsv_bus.valid);
      @(negedge clk);
    end
  end

  // called at a falling edge, returns at the falling edge after the word is taken
  task send_pixel(logic [CB-1:0] r, logic [CB-1:0] g, logic [CB-1:0] b);
    int gap;
    gap = steady ? 0 : $urandom_range(0, 7);
    if (gap > 0) begin
      pix_bus.valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    pix_bus.valid <= 1'b1;
    pix_bus.red   <= r;
    pix_bus.green <= g;
    pix_bus.blue  <= b;
    do @(posedge clk); while (!pix_bus.ready);
    @(negedge clk);
  endtask

  task send_random(int count);
    logic [CB-1:0] r, g, b, m, o;
    int k;
    repeat (count) begin
      case ($urandom_range(0, 7))
        0: begin
          r = CB'($urandom_range(0, CMAX));
          g = r;
          b = r;
        end
        1: begin
          m = CB'($urandom_range(1, CMAX));
          o = CB'($urandom_range(0, m - 1));
          k = int'($urandom_range(0, 2));
          r = (k == 0) ? o : m;
          g = (k == 1) ? o : m;
          b = (k == 2) ? o : m;
        end
        2: begin
          m = CB'($urandom_range(0, CMAX - 2));
          r = m + CB'($urandom_range(0, 2));
          g = m + CB'($urandom_range(0, 2));
          b = m + CB'($urandom_range(0, 2));
        end
        3: begin
          r = ($urandom_range(0, 1) != 0) ? CB'(CMAX - $urandom_range(0, 1))
                                          : CB'($urandom_range(0, 1));
          g = ($urandom_range(0, 1) != 0) ? CB'(CMAX - $urandom_range(0, 1))
                                          : CB'($urandom_range(0, 1));
          b = ($urandom_range(0, 1) != 0) ? CB'(CMAX - $urandom_range(0, 1))
                                          : CB'($urandom_range(0, 1));
        end
        default: begin
          r = CB'($urandom);
          g = CB'($urandom);
          b = CB'($urandom);
        end
      endcase
      send_pixel(r, g, b);
    end
  endtask

  task wait_drained();
    pix_bus.valid <= 1'b0;
    while (sb.pending() != 0) @(negedge clk);
  endtask

  initial begin
    cycles        = 0;
    steady        = 1'b0;
    rst_n         = 1'b0;
    pix_bus.valid = 1'b0;
    pix_bus.red   = '0;
    pix_bus.green = '0;
    pix_bus.blue  = '0;
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    foreach (corner_pixels[i])
      send_pixel(corner_pixels[i][23:16], corner_pixels[i][15:8], corner_pixels[i][7:0]);
    wait_drained();

    steady = 1'b1;
    send_random(250);
    steady = 1'b0;
    wait_drained();
    send_random(250);
    wait_drained();
    send_random(500);
    wait_drained();
    repeat (2 * quot_bits(CB) + 8) @(posedge clk);

    if (sb.failures == 0 && sb.pending() == 0)
      $display("Verification passed");
    else
      $display("Verification failed");
    $finish;
  end

endmodule
